// File: rtl/core/lsp_pkg.sv
package lsp_pkg;

    localparam int NUM_SENSORS = 7;
    localparam int SAMPLE_W    = 12;
    localparam int THRESH_W    = 7;
    localparam int SCALED_W    = 7;
    localparam int SUM_W       = 15;
    localparam int ACTIVE_W    = 3;
    localparam int POS_W       = 13;
    localparam int IDLE_W      = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 7;

    localparam logic [6:0]       SCALE_MUL = 7'd100;
    localparam int               SCALE_SHIFT = 12;
    localparam logic [POS_W-1:0] POS_MAX = 13'd7000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_6   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR = 4'd7;

    typedef enum logic [1:0] {
        SIDE_MIDDLE = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2
    } side_t;

    typedef logic [2:0] sensor_idx_t;

    // Sensors are scanned in this order when counting active hits.
    localparam sensor_idx_t SCAN_ORDER [NUM_SENSORS] = '{
        3'd0, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };

    localparam logic [SUM_W-1:0] WEIGHT [NUM_SENSORS] = '{
        15'd1000, 15'd2000, 15'd3000, 15'd4000, 15'd5000, 15'd6000, 15'd7000
    };

    localparam int NUM_SHAPES = 11;
    localparam logic [NUM_SENSORS-1:0] SHAPE_OK [NUM_SHAPES] = '{
        7'h60, 7'h18, 7'h06, 7'h30, 7'h0C, 7'h03,
        7'h38, 7'h07, 7'h70, 7'h0E, 7'h1C
    };

    typedef struct packed {
        logic [NUM_SENSORS-1:0] mask;
        logic                   err;
        logic [ACTIVE_W-1:0]    active;
        logic [SUM_W-1:0]       sum;
        side_t                  side;
    } merge_t;

    // Packed so that position lands in the lowest bits of tdata.
    typedef struct packed {
        side_t                  side_seen;
        logic [IDLE_W-1:0]      idle_ticks;
        logic                   line_lost;
        logic                   pattern_error;
        logic [NUM_SENSORS-1:0] hit_mask;
        logic [POS_W-1:0]       position;
    } result_t;

endpackage

// File: rtl/core/lsp_lane.sv
module lsp_lane
    import lsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [THRESH_W-1:0] thresh,
    input  logic                black,
    output logic                hit
);

    logic [SAMPLE_W+6:0]   product;
    logic [SCALED_W-1:0]   scaled;
    logic                  above;
    logic                  hit_reg;

    assign product = sample * SCALE_MUL;
    assign scaled  = product[SAMPLE_W+6:SCALE_SHIFT];
    assign above   = scaled > thresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (load)
        begin
            hit_reg <= black ? above : !above;
        end
    end

    assign hit = hit_reg;

endmodule

// File: rtl/core/lsp_merge.sv
module lsp_merge
    import lsp_pkg::*;
(
    input  logic [NUM_SENSORS-1:0] hits,
    input  logic                   black,
    input  side_t                  last_side,
    input  logic [ACTIVE_W-1:0]    saved_active,
    input  logic [SUM_W-1:0]       saved_sum,
    output merge_t                 result
);

    logic [ACTIVE_W-1:0] cnt;
    logic [SUM_W-1:0]    sum;
    side_t               side;
    sensor_idx_t         idx;
    logic                blocked;
    side_t               new_side;
    logic [2:0]          ones;
    logic                shape_hit;
    logic                valid;

    // Sensor scan with outer-sensor suppression, then the shape check.
    always_comb
    begin
        cnt      = '0;
        sum      = '0;
        side     = last_side;
        idx      = '0;
        blocked  = 1'b0;
        new_side = SIDE_MIDDLE;
        for (int k = 0; k < NUM_SENSORS; k++)
        begin
            idx = SCAN_ORDER[k];
            if (hits[idx])
            begin
                sum = sum + WEIGHT[idx];
                case (idx)
                    3'd0:
                    begin
                        blocked  = (cnt == '0) && (side == SIDE_LEFT);
                        new_side = SIDE_RIGHT;
                    end
                    3'd6:
                    begin
                        blocked  = (cnt == '0) && (side == SIDE_RIGHT);
                        new_side = SIDE_LEFT;
                    end
                    3'd1:
                    begin
                        blocked  = black && (cnt == '0) && (side == SIDE_LEFT);
                        new_side = SIDE_MIDDLE;
                    end
                    3'd5:
                    begin
                        blocked  = black && (cnt == '0) && (side == SIDE_RIGHT);
                        new_side = SIDE_MIDDLE;
                    end
                    default:
                    begin
                        blocked  = 1'b0;
                        new_side = SIDE_MIDDLE;
                    end
                endcase
                if (!blocked)
                begin
                    side = new_side;
                    cnt  = cnt + 3'd1;
                end
            end
        end

        ones = '0;
        for (int b = 0; b < NUM_SENSORS; b++)
        begin
            ones = ones + {2'b00, hits[b]};
        end
        shape_hit = 1'b0;
        for (int s = 0; s < NUM_SHAPES; s++)
        begin
            if (hits == SHAPE_OK[s])
            begin
                shape_hit = 1'b1;
            end
        end
        valid = (ones <= 3'd1) || shape_hit;

        result.mask = hits;
        result.err  = !valid;
        if (valid)
        begin
            result.active = cnt;
            result.sum    = sum;
            result.side   = side;
        end
        else
        begin
            result.active = saved_active;
            result.sum    = saved_sum;
            result.side   = SIDE_MIDDLE;
        end
    end

endmodule

// File: rtl/core/lsp_div.sv
module lsp_div
    import lsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [ACTIVE_W-1:0] divisor,
    output logic                done,
    output logic [SUM_W-1:0]    quotient
);

    localparam int WORK_W   = SUM_W + 1;
    localparam int STEPS    = 4;
    localparam int CYCLES   = WORK_W / STEPS;
    localparam int CNT_W    = $clog2(CYCLES);

    logic [WORK_W-1:0]   work_reg;
    logic [ACTIVE_W-1:0] rem_reg;
    logic [ACTIVE_W-1:0] div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [WORK_W-1:0]   work_next;
    logic [ACTIVE_W-1:0] rem_next;
    logic [ACTIVE_W:0]   trial;

    // Restoring division, four quotient bits per cycle.
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int s = 0; s < STEPS; s++)
        begin
            trial     = {rem_next, work_next[WORK_W-1]};
            work_next = {work_next[WORK_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial        = trial - {1'b0, div_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[ACTIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            work_reg <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                work_reg <= {1'b0, dividend};
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[SUM_W-1:0];

endmodule

// File: rtl/core/line_sensor_position_estimator_unit.sv
// An accepted item passes from the lane registers through ST_MERGE, the divider in
// ST_DIV and ST_OUT into the output register; a lost line skips the divide. No new
// item is taken until the last one has reached the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) clears thresholds, line color, side,
// saved count and sum, idle counter and all handshake state.
module line_sensor_position_estimator_unit
    import lsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample_0 .. sample_6, 12 bits each, from bit 0 up; bits 87:84 zero
    input  logic [87:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // position[12:0], hit_mask[19:13], pattern_error[20], line_lost[21],
    // idle_ticks[37:22], side_seen[39:38]
    output logic [39:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [THRESH_W-1:0]  thresh_reg [NUM_SENSORS];
    logic                 color_reg;
    side_t                side_reg;
    logic [ACTIVE_W-1:0]  saved_active_reg;
    logic [SUM_W-1:0]     saved_sum_reg;
    logic [IDLE_W-1:0]    idle_reg;
    result_t              res_reg;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic                   in_accept;
    logic [NUM_SENSORS-1:0] hits;
    merge_t                 merged;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;
    logic [POS_W-1:0]       pos_next;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_lane
        lsp_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (in_accept),
            .sample (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .thresh (thresh_reg[g]),
            .black  (color_reg),
            .hit    (hits[g])
        );
    end

    lsp_merge u_merge (
        .hits         (hits),
        .black        (color_reg),
        .last_side    (side_reg),
        .saved_active (saved_active_reg),
        .saved_sum    (saved_sum_reg),
        .result       (merged)
    );

    assign div_start = (state_reg == ST_MERGE) && (merged.active != '0);

    lsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (merged.sum),
        .divisor  (merged.active),
        .done     (div_done),
        .quotient (quotient)
    );

    // A suppressed outer hit can push the mean past the last sensor.
    assign pos_next = (quotient > {2'b00, POS_MAX}) ? POS_MAX : quotient[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                thresh_reg[i] <= '0;
            end
            color_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index <= REG_THRESH_6)
            begin
                thresh_reg[cfg_index[2:0]] <= cfg_data[THRESH_W-1:0];
            end
            else if (cfg_index == REG_LINE_COLOR)
            begin
                color_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            side_reg         <= SIDE_MIDDLE;
            saved_active_reg <= '0;
            saved_sum_reg    <= '0;
            idle_reg         <= '0;
            res_reg          <= '0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // In ST_OUT the output register is reloaded below instead.
            if (out_valid_reg && m_tready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    side_reg <= merged.side;
                    if (!merged.err)
                    begin
                        saved_active_reg <= merged.active;
                        saved_sum_reg    <= merged.sum;
                    end
                    res_reg.hit_mask      <= merged.mask;
                    res_reg.pattern_error <= merged.err;
                    res_reg.side_seen     <= merged.side;
                    res_reg.position      <= '0;
                    if (merged.active == '0)
                    begin
                        idle_reg           <= idle_reg + 1'b1;
                        res_reg.idle_ticks <= idle_reg + 1'b1;
                        res_reg.line_lost  <= 1'b1;
                        state_reg          <= ST_OUT;
                    end
                    else
                    begin
                        idle_reg           <= '0;
                        res_reg.idle_ticks <= '0;
                        res_reg.line_lost  <= 1'b0;
                        state_reg          <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg.position <= pos_next;
                        state_reg        <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

    // Only shapes of up to three sensors are ever saved.
    a_saved_small: assert property (@(posedge clk) disable iff (!rst_n)
        saved_active_reg <= 3'd3)
        else $error("saved active count above three");

    a_lost_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.line_lost |-> out_reg.position == '0)
        else $error("line lost with nonzero position");

    a_found_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.line_lost |-> out_reg.idle_ticks == '0)
        else $error("idle counter not cleared on a found line");

    a_err_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.pattern_error |-> out_reg.side_seen == SIDE_MIDDLE)
        else $error("bad shape did not recenter the side");

    a_pos_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.position <= POS_MAX)
        else $error("position above range");

endmodule

// File: verif/lsp_position_checker.sv
`timescale 1ns / 100ps

module lsp_position_checker
    import lsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [87:0]           s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    results_owed
);

    localparam logic [2:0] VISIT_SEQ [7] = '{3'd0, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
    localparam logic [6:0] PAIR_SHAPES [6] = '{7'h60, 7'h18, 7'h06, 7'h30, 7'h0C, 7'h03};
    localparam logic [6:0] TRIPLE_SHAPES [5] = '{7'h38, 7'h07, 7'h70, 7'h0E, 7'h1C};

    logic [6:0]  thresh [7];
    logic        black_line;
    side_t       last_side;
    logic [2:0]  saved_active;
    logic [14:0] saved_sum;
    logic [15:0] idle_count;
    result_t     positions_due [$];

    function automatic bit shape_valid(logic [6:0] mask);
        int n;
        bit ok;
        n = $countones(mask);
        ok = (n <= 1);
        if (n == 2)
        begin
            foreach (PAIR_SHAPES[j])
                if (mask == PAIR_SHAPES[j])
                    ok = 1'b1;
        end
        if (n == 3)
        begin
            foreach (TRIPLE_SHAPES[j])
                if (mask == TRIPLE_SHAPES[j])
                    ok = 1'b1;
        end
        return ok;
    endfunction

    // Updates the side, saved count and sum, and idle counter as one frame is processed.
    function automatic result_t estimate_position(logic [87:0] frame);
        result_t r;
        logic [6:0] mask;
        int sum;
        int active;
        int level;
        int idx;
        int k;
        bit hit;
        bit err;
        mask = '0;
        sum = 0;
        active = 0;
        for (k = 0; k < 7; k++)
        begin
            idx = VISIT_SEQ[k];
            level = (int'(frame[12*idx +: 12]) * 100) / 4096;
            hit = black_line ? (level > int'(thresh[idx])) : (level <= int'(thresh[idx]));
            if (hit)
            begin
                mask[idx] = 1'b1;
                sum += 1000 * (idx + 1);
                // An outer sensor does not count while nothing is active and the line
                // was last seen at the opposite end.
                if (idx == 0 || (black_line && idx == 1))
                begin
                    if (!(active == 0 && last_side == SIDE_LEFT))
                    begin
                        if (idx == 0)
                            last_side = SIDE_RIGHT;
                        else
                            last_side = SIDE_MIDDLE;
                        active++;
                    end
                end
                else if (idx == 6 || (black_line && idx == 5))
                begin
                    if (!(active == 0 && last_side == SIDE_RIGHT))
                    begin
                        if (idx == 6)
                            last_side = SIDE_LEFT;
                        else
                            last_side = SIDE_MIDDLE;
                        active++;
                    end
                end
                else
                begin
                    last_side = SIDE_MIDDLE;
                    active++;
                end
            end
        end

        err = !shape_valid(mask);
        if (err)
        begin
            active = saved_active;
            sum = saved_sum;
            last_side = SIDE_MIDDLE;
        end
        else
        begin
            saved_active = 3'(active);
            saved_sum = 15'(sum);
        end

        r.hit_mask = mask;
        r.pattern_error = err;
        r.line_lost = (active == 0);
        if (active == 0)
        begin
            idle_count = idle_count + 16'd1;
            r.position = '0;
        end
        else
        begin
            idle_count = '0;
            if (sum / active > int'(POS_MAX))
                r.position = POS_MAX;
            else
                r.position = POS_W'(sum / active);
        end
        r.idle_ticks = idle_count;
        r.side_seen = last_side;
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            foreach (thresh[j])
                thresh[j] = '0;
            black_line = 1'b0;
            last_side = SIDE_MIDDLE;
            saved_active = '0;
            saved_sum = '0;
            idle_count = '0;
            positions_due.delete();
            mismatches = 0;
            results_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index <= REG_THRESH_6)
                    thresh[cfg_index[2:0]] = cfg_data;
                else if (cfg_index == REG_LINE_COLOR)
                    black_line = cfg_data[0];
            end

            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (positions_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = positions_due.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("hit_mask", want.hit_mask, got.hit_mask);
                    check_field("pattern_error", want.pattern_error, got.pattern_error);
                    check_field("line_lost", want.line_lost, got.line_lost);
                    check_field("idle_ticks", want.idle_ticks, got.idle_ticks);
                    check_field("side_seen", want.side_seen, got.side_seen);
                end
            end

            if (s_tvalid && s_tready)
                positions_due.push_back(estimate_position(s_tdata));

            results_owed = positions_due.size();
        end
    end

endmodule

// File: verif/tb_line_sensor_position_estimator_unit.sv
`timescale 1ns / 100ps

module tb_line_sensor_position_estimator_unit;
    import lsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    localparam logic [6:0] LINE_SHAPES [19] = '{
        7'h00, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40,
        7'h60, 7'h18, 7'h06, 7'h30, 7'h0C, 7'h03,
        7'h38, 7'h07, 7'h70, 7'h0E, 7'h1C
    };

    // Line lost, a full bar, right end then a wide shape that overflows the position, left
    // end then a shape with suppressed outer hits, bad shapes, then valid ones and a lost line.
    localparam logic [6:0] OPENING_SHAPES [12] = '{
        7'h00, 7'h7F, 7'h01, 7'h70, 7'h40, 7'h07,
        7'h41, 7'h0D, 7'h0E, 7'h08, 7'h1C, 7'h00
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [87:0]           s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   mismatches;
    int   results_owed;
    int   rx_hold = 0;
    bit   calm = 1'b0;
    logic [6:0] thresh_set [7];
    bit   black_set;

    line_sensor_position_estimator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lsp_position_checker position_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Raw reading whose scaled value is exactly the given level.
    function automatic logic [11:0] reading_at(int level);
        int lo;
        int hi;
        lo = (level * 4096 + 99) / 100;
        hi = (level >= 99) ? 4095 : ((level + 1) * 4096 + 99) / 100 - 1;
        return 12'($urandom_range(hi, lo));
    endfunction

    function automatic logic [11:0] reading_for(int th, bit hit);
        int lo;
        int hi;
        int level;
        bit above;
        above = (hit == black_set);
        if (above && th >= 99)
            above = 1'b0;
        lo = above ? th + 1 : 0;
        hi = above ? 99 : ((th > 99) ? 99 : th);
        case ($urandom_range(3))
            0: level = lo;
            1: level = hi;
            default: level = $urandom_range(hi, lo);
        endcase
        return reading_at(level);
    endfunction

    function automatic logic [87:0] frame_for(logic [6:0] mask);
        logic [87:0] f;
        f = '0;
        for (int i = 0; i < 7; i++)
            f[12*i +: 12] = reading_for(thresh_set[i], mask[i]);
        return f;
    endfunction

    function automatic logic [87:0] raw_frame();
        logic [87:0] f;
        f = '0;
        for (int i = 0; i < 7; i++)
            f[12*i +: 12] = 12'($urandom);
        return f;
    endfunction

    // Leaves s_tvalid high after the accept so that back-to-back items need no toggle.
    task automatic send_frame(logic [87:0] frame);
        int gap;
        gap = calm ? 0 : $urandom_range(3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= frame;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic program_unit(input logic [6:0] th [7], input bit color, input bit stray);
        settle();
        for (int i = 0; i < 7; i++)
        begin
            write_reg(CFG_IDX_W'(REG_THRESH_0 + i), th[i]);
            thresh_set[i] = th[i];
        end
        write_reg(REG_LINE_COLOR, 7'(color));
        black_set = color;
        // An index past the register list must leave everything unchanged.
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(15, 8)), 7'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int w;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            w = calm ? 0 : $urandom_range(3);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_line_sensor_position_estimator_unit NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [6:0] th [7];
        int p;
        int n;
        int budget;
        int r;
        int len;
        bit color;
        bit stray;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (thresh_set[i])
            thresh_set[i] = '0;
        black_set = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds are zero on a white line: zero readings hit everywhere,
        // full-scale readings nowhere.
        send_frame('0);
        send_frame({4'h0, {7{12'hFFF}}});

        th = '{default: 7'd50};
        program_unit(th, 1'b1, 1'b0);
        foreach (OPENING_SHAPES[i])
            send_frame(frame_for(OPENING_SHAPES[i]));

        th = '{7'd0, 7'd100, 7'd127, 7'd0, 7'd100, 7'd50, 7'd127};
        program_unit(th, 1'b0, 1'b1);
        send_frame({4'h0, {7{12'hAAA}}});
        send_frame({4'h0, {7{12'h555}}});
        send_frame('0);
        send_frame({4'h0, {7{12'hFFF}}});
        send_frame(frame_for(7'h7F));
        send_frame(frame_for(7'h00));

        for (p = 0; p < 6; p++)
        begin
            stray = 1'b0;
            case (p)
                0:
                begin
                    foreach (th[i])
                        th[i] = 7'($urandom_range(80, 20));
                    color = 1'b1;
                end
                1:
                begin
                    foreach (th[i])
                        th[i] = 7'($urandom_range(100, 0));
                    color = 1'b0;
                end
                2:
                begin
                    th = '{default: 7'd0};
                    color = 1'b1;
                end
                3:
                begin
                    th = '{default: 7'd100};
                    color = 1'b0;
                end
                4:
                begin
                    foreach (th[i])
                        th[i] = 7'($urandom_range(127, 0));
                    th[$urandom_range(6)] = 7'd127;
                    color = 1'($urandom);
                    stray = 1'b1;
                end
                default:
                begin
                    foreach (th[i])
                        th[i] = 7'($urandom_range(100, 0));
                    color = 1'b1;
                end
            endcase
            program_unit(th, color, stray);

            budget = (p == 3) ? 60 : 290;
            n = 0;
            while (n < budget)
            begin
                calm = (p % 2 == 1) && (n < 100);
                // Hold the output off long enough for the unit to back up its input.
                if (p == 1 && n == 40)
                    rx_hold = 400;
                r = $urandom_range(99);
                if (r < 8)
                begin
                    len = $urandom_range(10, 2);
                    repeat (len) send_frame(frame_for(7'h00));
                    n += len;
                end
                else
                begin
                    if (r < 75)
                        send_frame(frame_for(LINE_SHAPES[$urandom_range(18)]));
                    else if (r < 88)
                        send_frame(frame_for(7'($urandom)));
                    else
                        send_frame(raw_frame());
                    n++;
                end
            end
            calm = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("tb_line_sensor_position_estimator_unit OK");
        else
            $display("tb_line_sensor_position_estimator_unit NOT OK");
        $finish;
    end

endmodule
